FILE: rtl/assert_macros.svh
// Assertion macros used by the checked module of the channel router.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UMX_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UMX_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/umx_pkg.sv
// Package for the upmix, channel remap and gain block.
// Holds widths, word types, the route and gain tables and the index wrap function.
`timescale 1ns / 1ps

package umx_pkg;

	localparam int NumCh    = 6;
	localparam int NumRows  = 4;
	localparam int SampleW  = 16;
	localparam int GainW    = 16;
	localparam int CountW   = 3;
	localparam int SelW     = 2;
	localparam int IdxW     = 3;
	localparam int FracBits = 15;
	localparam int MagW     = SampleW + 1;
	localparam int ProdW    = MagW + GainW;

	typedef logic [IdxW-1:0]      ch_idx_t;
	typedef logic [GainW-1:0]     gain_t;
	typedef logic signed [SampleW-1:0] sample_t;

	// Rows three and zero are the same, so an unused selector falls back to row zero.
	localparam ch_idx_t RouteTab [NumRows][NumCh] = '{
		'{3'd0, 3'd1, 3'd4, 3'd5, 3'd2, 3'd3},
		'{3'd1, 3'd5, 3'd0, 3'd4, 3'd2, 3'd3},
		'{3'd0, 3'd1, 3'd4, 3'd5, 3'd2, 3'd3},
		'{3'd0, 3'd1, 3'd4, 3'd5, 3'd2, 3'd3}
	};

	// Unsigned Q1.15 gains, 32768 is unity.
	localparam gain_t GainTab [NumRows][NumCh] = '{
		'{16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768},
		'{16'd22938, 16'd32768, 16'd13107, 16'd29491, 16'd13107, 16'd32768},
		'{16'd32768, 16'd29491, 16'd29491, 16'd22938, 16'd13107, 16'd32768},
		'{16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768}
	};

	typedef struct packed {
		logic [CountW-1:0] channel_count;
		logic [SelW-1:0]   map_select;
		sample_t           in_sample_0;
		sample_t           in_sample_1;
		sample_t           in_sample_2;
		sample_t           in_sample_3;
		sample_t           in_sample_4;
		sample_t           in_sample_5;
		logic              last_frame;
	} frame_word_t;

	typedef struct packed {
		sample_t out_sample_0;
		sample_t out_sample_1;
		sample_t out_sample_2;
		sample_t out_sample_3;
		sample_t out_sample_4;
		sample_t out_sample_5;
		logic    frame_end;
	} result_word_t;

	typedef struct packed {
		logic [MagW-1:0] mag;
		logic            neg;
		gain_t           gain;
	} lane_s1_t;

	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

	// Upmix wrap: channel k of the six-channel frame copies input channel k mod count.
	// A count of zero acts as one and a count of seven acts as six.
	function automatic ch_idx_t wrap_idx(ch_idx_t k, logic [CountW-1:0] count);
		ch_idx_t c;
		ch_idx_t r;
		if (count == '0) begin
			c = ch_idx_t'(1);
		end else if (count > CountW'(NumCh)) begin
			c = ch_idx_t'(NumCh);
		end else begin
			c = ch_idx_t'(count);
		end
		r = k;
		for (int i = 0; i < NumCh - 1; i++) begin
			if (r >= c) begin
				r = r - c;
			end
		end
		return r;
	endfunction

endpackage

FILE: rtl/umx_frame_if.sv
// Input channel of the channel router: valid, ready and one frame word.
// Depends on umx_pkg for the word type.
`timescale 1ns / 1ps

interface umx_frame_if;
	import umx_pkg::*;

	logic        valid;
	logic        ready;
	frame_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/umx_result_if.sv
// Output channel of the channel router: valid, ready and one result word.
// Depends on umx_pkg for the word type.
`timescale 1ns / 1ps

interface umx_result_if;
	import umx_pkg::*;

	logic         valid;
	logic         ready;
	result_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/umx_route.sv
// First pipeline stage: upmix wrap, table route, sample magnitude and gain lookup.
// Depends on umx_pkg for tables, types and the wrap function.
`timescale 1ns / 1ps

module umx_route (
	input  logic                                    clk,
	input  logic                                    en,
	input  umx_pkg::frame_word_t                    frame_word,
	output umx_pkg::lane_s1_t [umx_pkg::NumCh-1:0]  lane_s1
);
	import umx_pkg::*;

	sample_t  src [NumCh];
	lane_s1_t lane_d [NumCh];

	assign src[0] = frame_word.in_sample_0;
	assign src[1] = frame_word.in_sample_1;
	assign src[2] = frame_word.in_sample_2;
	assign src[3] = frame_word.in_sample_3;
	assign src[4] = frame_word.in_sample_4;
	assign src[5] = frame_word.in_sample_5;

	for (genvar j = 0; j < NumCh; j++) begin : g_ch
		ch_idx_t         pick;
		sample_t         smp;
		logic [MagW-1:0] ext;

		always_comb begin
			pick = wrap_idx(RouteTab[frame_word.map_select][j], frame_word.channel_count);
			smp  = src[pick];
			ext  = {smp[SampleW-1], smp};
			lane_d[j].neg  = smp[SampleW-1];
			lane_d[j].mag  = smp[SampleW-1] ? (~ext + 1'b1) : ext;
			lane_d[j].gain = GainTab[frame_word.map_select][j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lane_s1[j] <= lane_d[j];
			end
		end
	end
endmodule

FILE: rtl/umx_lane.sv
// Second and third pipeline stages of one channel: Q1.15 multiply, then shift
// and sign restore. Depends on umx_pkg for widths and stage types.
`timescale 1ns / 1ps

module umx_lane (
	input  logic               clk,
	input  umx_pkg::stage_en_t en,
	input  umx_pkg::lane_s1_t  lane_s1,
	output umx_pkg::sample_t   out_sample
);
	import umx_pkg::*;

	logic [ProdW-1:0] prod_s2;
	logic             neg_s2;
	logic [MagW-1:0]  shifted;
	logic [MagW-1:0]  signed_res;
	sample_t          out_s3;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= ProdW'(lane_s1.mag) * ProdW'(lane_s1.gain);
			neg_s2  <= lane_s1.neg;
		end
	end

	// Truncation toward zero: shift the magnitude, then restore the sign.
	always_comb begin
		shifted    = prod_s2[FracBits +: MagW];
		signed_res = neg_s2 ? (~shifted + 1'b1) : shifted;
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			out_s3 <= signed_res[SampleW-1:0];
		end
	end

	assign out_sample = out_s3;
endmodule

FILE: rtl/upmix_channel_remap_gain.sv
// Six-channel upmix, channel remap and fixed Q1.15 gain. Takes one frame word per
// cycle and returns one result word per cycle while result.ready stays high; the
// three register stages that each frame passes are route and magnitude, the 17 by
// 16 bit multiply, and shift with sign restore. A stalled output holds its word
// while the earlier stages keep filling until all three are full. Depends on
// umx_pkg, umx_frame_if, umx_result_if, umx_route and umx_lane.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module upmix_channel_remap_gain (
	input  logic                clk,
	input  logic                arst_n,
	umx_frame_if.sink           frame,
	umx_result_if.source        result
);
	import umx_pkg::*;

	logic                       valid_s1, valid_s2, valid_s3;
	logic                       last_s1, last_s2, last_s3;
	logic                       adv1, adv2, adv3;
	stage_en_t                  lane_en;
	lane_s1_t [NumCh-1:0]       lane_s1;
	sample_t                    out_smp [NumCh];

	assign adv3 = !valid_s3 || result.ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign frame.ready = adv1;
	assign lane_en.s2  = adv2;
	assign lane_en.s3  = adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= frame.valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			last_s1 <= frame.data.last_frame;
		end
		if (adv2) begin
			last_s2 <= last_s1;
		end
		if (adv3) begin
			last_s3 <= last_s2;
		end
	end

	umx_route u_route (
		.clk        (clk),
		.en         (adv1),
		.frame_word (frame.data),
		.lane_s1    (lane_s1)
	);

	for (genvar j = 0; j < NumCh; j++) begin : g_lane
		umx_lane u_lane (
			.clk        (clk),
			.en         (lane_en),
			.lane_s1    (lane_s1[j]),
			.out_sample (out_smp[j])
		);
	end

	assign result.valid             = valid_s3;
	assign result.data.out_sample_0 = out_smp[0];
	assign result.data.out_sample_1 = out_smp[1];
	assign result.data.out_sample_2 = out_smp[2];
	assign result.data.out_sample_3 = out_smp[3];
	assign result.data.out_sample_4 = out_smp[4];
	assign result.data.out_sample_5 = out_smp[5];
	assign result.data.frame_end    = last_s3;

	`UMX_ASSERT_NXT(a_accept_fills_s1, frame.valid && frame.ready, valid_s1, "accepted word missing from stage one")
	`UMX_ASSERT_NXT(a_stall_keeps_words, valid_s2 && valid_s3 && !result.ready, valid_s2 && valid_s3, "word lost during output stall")
	`UMX_ASSERT_NXT(a_s1_moves_on, valid_s1 && adv2, valid_s2, "stage one word not passed to stage two")
	`UMX_ASSERT_IMP(a_full_blocks_input, valid_s1 && valid_s2 && valid_s3 && !result.ready, !frame.ready, "input taken while pipeline is full")
endmodule

FILE: tb/testbench.sv
// Testbench for the upmix, channel remap and gain block: drives frame words with random
// gaps and stalls and checks every result word against a local prediction of the block.
// Depends on umx_pkg, umx_frame_if, umx_result_if and upmix_channel_remap_gain.
`timescale 1ns / 1ps

module testbench;
	import umx_pkg::*;

	localparam logic [SelW-1:0] SelDirect = 2'd0;
	localparam logic [SelW-1:0] SelRemix  = 2'd1;
	localparam logic [SelW-1:0] SelTrim   = 2'd2;
	localparam logic [SelW-1:0] SelSpare  = 2'd3;

	localparam int CycleLimit = 400000;

	localparam int RouteMap [3][6] = '{
		'{0, 1, 4, 5, 2, 3},
		'{1, 5, 0, 4, 2, 3},
		'{0, 1, 4, 5, 2, 3}
	};
	localparam int GainQ15 [3][6] = '{
		'{32768, 32768, 32768, 32768, 32768, 32768},
		'{22938, 32768, 13107, 29491, 13107, 32768},
		'{32768, 29491, 29491, 22938, 13107, 32768}
	};

	logic clk;
	logic arst_n;

	umx_frame_if  frame_bus ();
	umx_result_if result_bus ();

	upmix_channel_remap_gain uut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_bus),
		.result (result_bus)
	);

	result_word_t expected_results [$];
	int           error_count;
	int           results_seen;
	int           cycle_count;
	bit           send_idle;
	bit           recv_idle;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count,
				expected_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic result_word_t remap_frame(frame_word_t f);
		sample_t      src [6];
		sample_t      res [6];
		int           cnt;
		int           row;
		int           smp;
		int           prod;
		result_word_t r;
		src = '{f.in_sample_0, f.in_sample_1, f.in_sample_2,
			f.in_sample_3, f.in_sample_4, f.in_sample_5};
		cnt = f.channel_count;
		if (cnt == 0) begin
			cnt = 1;
		end
		if (cnt > 6) begin
			cnt = 6;
		end
		row = (f.map_select == SelSpare) ? int'(SelDirect) : int'(f.map_select);
		for (int j = 0; j < 6; j++) begin
			smp = src[RouteMap[row][j] % cnt];
			prod = ((smp < 0 ? -smp : smp) * GainQ15[row][j]) >> 15;
			res[j] = sample_t'(smp < 0 ? -prod : prod);
		end
		r.out_sample_0 = res[0];
		r.out_sample_1 = res[1];
		r.out_sample_2 = res[2];
		r.out_sample_3 = res[3];
		r.out_sample_4 = res[4];
		r.out_sample_5 = res[5];
		r.frame_end    = f.last_frame;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		error_count++;
		$display("ERROR at result word %0d: %s is %0d, expected %0d", results_seen, what,
			got, want);
	endtask

	task automatic check_result(result_word_t got);
		result_word_t want;
		sample_t      g [6];
		sample_t      w [6];
		if (expected_results.size() == 0) begin
			report_mismatch("result word with nothing pending, out_sample_0",
				got.out_sample_0, 0);
		end else begin
			want = expected_results.pop_front();
			g = '{got.out_sample_0, got.out_sample_1, got.out_sample_2,
				got.out_sample_3, got.out_sample_4, got.out_sample_5};
			w = '{want.out_sample_0, want.out_sample_1, want.out_sample_2,
				want.out_sample_3, want.out_sample_4, want.out_sample_5};
			for (int j = 0; j < 6; j++) begin
				if (g[j] !== w[j]) begin
					report_mismatch($sformatf("out_sample_%0d", j), g[j], w[j]);
				end
			end
			if (got.frame_end !== want.frame_end) begin
				report_mismatch("frame_end", got.frame_end, want.frame_end);
			end
		end
		results_seen++;
	endtask

	initial begin
		int hold;
		hold = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_bus.valid && result_bus.ready) begin
				check_result(result_bus.data);
				hold = recv_idle ? $urandom_range(0, 14) : 0;
			end
			if (!arst_n) begin
				result_bus.ready <= 1'b0;
			end else if (hold > 0) begin
				result_bus.ready <= 1'b0;
				hold--;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	task automatic send_frame(logic [CountW-1:0] count, logic [SelW-1:0] sel,
			sample_t s [6], logic last);
		frame_word_t w;
		int          gap;
		w.channel_count = count;
		w.map_select    = sel;
		w.in_sample_0   = s[0];
		w.in_sample_1   = s[1];
		w.in_sample_2   = s[2];
		w.in_sample_3   = s[3];
		w.in_sample_4   = s[4];
		w.in_sample_5   = s[5];
		w.last_frame    = last;
		gap = send_idle ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			frame_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		expected_results.push_back(remap_frame(w));
		frame_bus.valid <= 1'b1;
		frame_bus.data  <= w;
		do begin
			@(posedge clk);
		end while (!frame_bus.ready);
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return sample_t'(-32768);
			1: return sample_t'(32767);
			2: return sample_t'(-1);
			3: return sample_t'($urandom_range(0, 1));
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic test_row_extremes();
		sample_t s [6];
		for (int sel = 0; sel < 4; sel++) begin
			s = '{default: sample_t'(-32768)};
			send_frame(3'd6, sel[SelW-1:0], s, 1'b0);
			s = '{default: sample_t'(32767)};
			send_frame(3'd6, sel[SelW-1:0], s, 1'b1);
			s = '{sample_t'(-32768), sample_t'(32767), sample_t'(-1), sample_t'(1),
				sample_t'(0), sample_t'(16'h5555)};
			send_frame(3'd6, sel[SelW-1:0], s, sel[0]);
		end
	endtask

	task automatic test_channel_counts();
		sample_t s [6];
		s = '{sample_t'(16'h1111), sample_t'(-16'sh2222), sample_t'(16'h3333),
			sample_t'(-16'sh4444), sample_t'(16'h5555), sample_t'(-16'sh6666)};
		for (int c = 0; c < 8; c++) begin
			send_frame(c[CountW-1:0], c[SelW-1:0], s, c[2]);
		end
	endtask

	task automatic test_truncation();
		sample_t s [6];
		s = '{sample_t'(-1), sample_t'(1), sample_t'(-3), sample_t'(3), sample_t'(-2),
			sample_t'(2)};
		send_frame(3'd6, SelRemix, s, 1'b0);
		send_frame(3'd6, SelTrim, s, 1'b1);
	endtask

	task automatic test_pause_until_empty();
		frame_bus.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_random_frames(int n);
		sample_t s [6];
		for (int i = 0; i < n; i++) begin
			if (i % 150 == 0) begin
				send_idle = ((i / 150) % 4) != 1;
				recv_idle = ((i / 150) % 4) != 2;
			end
			foreach (s[j]) begin
				s[j] = pick_sample();
			end
			send_frame(($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(1, 6)), 2'($urandom_range(0, 3)), s,
				$urandom_range(0, 7) == 0);
		end
	endtask

	initial begin
		cycle_count = 0;
		error_count = 0;
		results_seen = 0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		arst_n <= 1'b0;
		frame_bus.valid <= 1'b0;
		frame_bus.data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_row_extremes();
		test_channel_counts();
		test_truncation();
		test_pause_until_empty();
		test_random_frames(1950);
		frame_bus.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/umx_pkg.sv
rtl/umx_frame_if.sv
rtl/umx_result_if.sv
rtl/umx_route.sv
rtl/umx_lane.sv
rtl/upmix_channel_remap_gain.sv
tb/testbench.sv
